// File: rtl/core/mse_pkg.sv
// Shared types and constants for the multi-stack engine.
package mse_pkg;

  // Default sizing of the engine
  localparam int NUM_STACKS_DEF = 8;
  localparam int MAX_DEPTH_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Field widths on the ports
  localparam int CMD_W    = 2;
  localparam int SID_W    = 3;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CAPREG_W = 7;
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = 3;
  localparam int WIDE_W   = 64;

  // Packed stream payloads, rounded up to whole bytes
  localparam int IN_BITS      = CMD_W + SID_W + VAL_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = VAL_W + 1 + 1 + STATUS_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NO_STACK  = 2'd3
  } status_t;

  // Where the result's top value comes from
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_MEM  = 2'd1,
    SRC_PUSH = 2'd2
  } top_src_t;

  // Result fields carried from the accept stage to the output stage
  typedef struct packed {
    status_t          status;
    logic             empty;
    logic             full;
    top_src_t         src;
    logic [VAL_W-1:0] push_val;
  } res_t;

endpackage

// File: rtl/core/multi_stack_engine_top.sv
// Multi-stack engine: several LIFO stacks sharing one entry memory.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | slave     | in_tvalid/in_tready  | in_tdata: cmd, stack_id, push_value
//  out_    | master    | out_tvalid/out_tready| out_tdata: top_value, empty, full, status
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data (stack capacity)
//
// One item per cycle while the output is not stalled; each result passes the accept stage, then the result register.
// Fill counts sit in flip-flops; a push writes the entry memory; a pop leaving entries,
// a top read or an overflowing push issues one read, so the single read port sets the rate.
// Reset empties all stacks and sets all capacities to zero; no clearing pass.
// A stalled output holds the result register and the accept stage behind it.
module multi_stack_engine_top #(
  parameter int NUM_STACKS = mse_pkg::NUM_STACKS_DEF,
  parameter int MAX_DEPTH  = mse_pkg::MAX_DEPTH_DEF,
  parameter int DATA_WIDTH = mse_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // [1:0] cmd, [4:2] stack_id, [36:5] push_value, [39:37] zero
  input  logic [mse_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [31:0] top_value, [32] is_empty_flag, [33] is_full_flag, [35:34] status, [39:36] zero
  output logic [mse_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mse_pkg::CAPREG_W-1:0]     cfg_data
);

  import mse_pkg::*;

  localparam int MEM_DEPTH = NUM_STACKS * MAX_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int CAP_W     = (CNT_W > CAPREG_W) ? CNT_W : CAPREG_W;

  // Input fields
  logic [CMD_W-1:0]      cmd;
  logic [SID_W-1:0]      sid;
  logic [VAL_W-1:0]      push_value;
  logic [WIDE_W-1:0]     val_wide;
  logic [DATA_WIDTH-1:0] val_dw;
  logic [WIDE_W-1:0]     val_dw_ext;
  logic [VAL_W-1:0]      val_top;

  assign cmd        = in_tdata[CMD_W-1:0];
  assign sid        = in_tdata[CMD_W+SID_W-1:CMD_W];
  assign push_value = in_tdata[CMD_W+SID_W+VAL_W-1:CMD_W+SID_W];
  assign val_wide   = WIDE_W'(push_value);
  assign val_dw     = val_wide[DATA_WIDTH-1:0];
  assign val_dw_ext = WIDE_W'(val_dw);
  assign val_top    = val_dw_ext[VAL_W-1:0];

  // State
  logic [CAPREG_W-1:0] cap_r  [NUM_REGS];
  logic [CNT_W-1:0]    fill_r [NUM_STACKS];

  logic       s1_valid_r;
  res_t       s1_r;
  logic       out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // Handshakes
  logic in_acc;
  logic cfg_acc;
  logic s1_adv;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Decode the operation against the addressed stack
  logic             exists;
  logic [CNT_W-1:0] fill_cur;
  logic [CAP_W-1:0] cap_ext;
  logic [CAP_W-1:0] cap_sat;
  logic [CNT_W-1:0] cap_cur;
  logic [CNT_W-1:0] fill_new;
  logic             fill_upd;
  logic             wr_req;
  logic             rd_req;
  logic [CNT_W-1:0] off;
  logic [ADDR_W-1:0] addr;
  res_t             res;

  always_comb begin
    fill_cur = '0;
    for (int s = 0; s < NUM_STACKS; s++) begin
      if (sid == SID_W'(s)) begin
        fill_cur = fill_r[s];
      end
    end
    exists  = (32'(sid) < NUM_STACKS) && (cap_r[sid] != '0);
    cap_ext = CAP_W'(cap_r[sid]);
    cap_sat = (cap_ext > CAP_W'(MAX_DEPTH)) ? CAP_W'(MAX_DEPTH) : cap_ext;
    cap_cur = CNT_W'(cap_sat);

    res.status   = ST_OK;
    res.empty    = 1'b0;
    res.full     = 1'b0;
    res.src      = SRC_ZERO;
    res.push_val = val_top;
    fill_new     = fill_cur;
    fill_upd     = 1'b0;
    wr_req       = 1'b0;
    rd_req       = 1'b0;
    off          = '0;

    if (!exists) begin
      res.status = ST_NO_STACK;
      res.empty  = 1'b1;
    end else begin
      unique case (cmd)
        CMD_PUSH: begin
          if (fill_cur >= cap_cur) begin
            res.status = ST_OVERFLOW;
            res.full   = 1'b1;
            res.src    = SRC_MEM;
            rd_req     = 1'b1;
            off        = fill_cur - CNT_W'(1);
          end else begin
            wr_req   = 1'b1;
            off      = fill_cur;
            fill_new = fill_cur + CNT_W'(1);
            fill_upd = 1'b1;
            res.src  = SRC_PUSH;
            res.full = (fill_new == cap_cur);
          end
        end
        CMD_POP: begin
          if (fill_cur == '0) begin
            res.status = ST_UNDERFLOW;
            res.empty  = 1'b1;
          end else begin
            fill_new  = fill_cur - CNT_W'(1);
            fill_upd  = 1'b1;
            res.empty = (fill_new == '0);
            if (fill_new != '0) begin
              res.src = SRC_MEM;
              rd_req  = 1'b1;
              off     = fill_cur - CNT_W'(2);
            end
          end
        end
        default: begin
          if (fill_cur == '0) begin
            res.status = ST_UNDERFLOW;
            res.empty  = 1'b1;
          end else begin
            res.src  = SRC_MEM;
            rd_req   = 1'b1;
            off      = fill_cur - CNT_W'(1);
            res.full = (fill_cur == cap_cur);
          end
        end
      endcase
    end

    addr = ADDR_W'(32'(sid) * MAX_DEPTH + 32'(off));
  end

  // Entry memory
  logic [DATA_WIDTH-1:0] rd_data;
  logic [WIDE_W-1:0]     rd_ext;
  logic [VAL_W-1:0]      rd_top;

  mse_entry_ram #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_WIDTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (in_acc && wr_req),
    .wr_addr (addr),
    .wr_data (val_dw),
    .rd_en   (in_acc && rd_req),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  assign rd_ext = WIDE_W'(rd_data);
  assign rd_top = rd_ext[VAL_W-1:0];

  // Capacities and fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        cap_r[r] <= '0;
      end
      for (int s = 0; s < NUM_STACKS; s++) begin
        fill_r[s] <= '0;
      end
    end else begin
      if (cfg_acc) begin
        cap_r[cfg_index] <= cfg_data;
      end
      for (int s = 0; s < NUM_STACKS; s++) begin
        if (cfg_acc && (cfg_index == CFG_IDX_W'(s))) begin
          fill_r[s] <= '0;
        end else if (in_acc && fill_upd && (sid == SID_W'(s))) begin
          fill_r[s] <= fill_new;
        end
      end
    end
  end

  // Advance the valid flags of both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Select the top value once the memory data has arrived
  logic [VAL_W-1:0] s1_top;

  always_comb begin
    unique case (s1_r.src)
      SRC_MEM:  s1_top = rd_top;
      SRC_PUSH: s1_top = s1_r.push_val;
      default:  s1_top = '0;
    endcase
  end

  // Hold payloads
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= res;
    end
    if (s1_adv) begin
      out_tdata_r <= OUT_TDATA_W'({s1_r.status, s1_r.full, s1_r.empty, s1_top});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTH
  // Every transfer fills the accept stage on the next cycle
  a_acc_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted item did not reach the accept stage");

  // A live stack never holds more entries than its capacity
  a_fill_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && exists) |-> (fill_cur <= cap_cur))
    else $error("fill count above capacity");

  // Overflow always reports a full stack with a valid top
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_r.status == ST_OVERFLOW)) |-> (s1_r.full && !s1_r.empty))
    else $error("overflow result without full flag");

  // Read data must survive while a waiting result that uses it is stalled
  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_r.src == SRC_MEM) && !s1_adv) |=> $stable(rd_data))
    else $error("memory read data changed under a stalled result");
`endif

endmodule

// File: rtl/core/mse_entry_ram.sv
// Entry store: one write port, one read port with registered read data.
module mse_entry_ram #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read entry, hold data while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sim/tb_top.sv
// Testbench for multi_stack_engine_top: directed and random stack traffic checked against a local model.
`timescale 1ns / 100ps

module tb_top;
  import mse_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_CYC   = 8;
  localparam int TAIL_CYC    = 8;
  localparam int CYCLE_LIMIT = 100000;
  localparam int STACKS      = 8;
  localparam int DEPTH       = 64;

  // Read-top codes; the spare code behaves as read-top
  localparam logic [CMD_W-1:0] CMD_TOP     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TOP_ALT = 2'd3;

  typedef struct packed {
    status_t          status;
    logic             full;
    logic             empty;
    logic [VAL_W-1:0] top;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CAPREG_W-1:0] cfg_data = '0;

  // Local copy of the engine state
  logic [CAPREG_W-1:0] cap_reg [STACKS];
  int                  fill_cnt [STACKS];
  logic [VAL_W-1:0]    entry_mem [STACKS][DEPTH];

  stack_result_t pending_results[$];
  int  mismatch_cnt = 0;
  int  cycle_cnt = 0;
  bit  gap_en = 1'b1;
  bit  stall_en = 1'b1;

  multi_stack_engine_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_tready <= stall_en ? ($urandom_range(99) >= 24) : 1'b1;
  end

  // Apply one operation to the local state and return what the engine should report
  function automatic stack_result_t apply_stack_op(logic [CMD_W-1:0] cmd,
                                                   logic [SID_W-1:0] sid,
                                                   logic [VAL_W-1:0] val);
    stack_result_t r;
    int cap;
    int cnt;
    cap = (cap_reg[sid] > DEPTH) ? DEPTH : int'(cap_reg[sid]);
    if (cap == 0) begin
      r.top = '0;
      r.empty = 1'b1;
      r.full = 1'b0;
      r.status = ST_NO_STACK;
      return r;
    end
    cnt = fill_cnt[sid];
    r.status = ST_OK;
    if (cmd == CMD_PUSH) begin
      if (cnt >= cap) begin
        r.status = ST_OVERFLOW;
      end else begin
        entry_mem[sid][cnt] = val;
        cnt++;
      end
    end else if (cmd == CMD_POP) begin
      if (cnt == 0) r.status = ST_UNDERFLOW;
      else cnt--;
    end else if (cnt == 0) begin
      r.status = ST_UNDERFLOW;
    end
    fill_cnt[sid] = cnt;
    r.top = (cnt > 0) ? entry_mem[sid][cnt-1] : '0;
    r.empty = (cnt == 0);
    r.full = (cnt == cap);
    return r;
  endfunction

  function automatic void check_field(string name, logic [VAL_W-1:0] exp_v,
                                      logic [VAL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endfunction

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    stack_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $realtime, out_tdata);
        mismatch_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        // out_tdata: [31:0] top, [32] empty, [33] full, [35:34] status
        check_field("top_value", exp_r.top, out_tdata[31:0]);
        check_field("is_empty_flag", VAL_W'(exp_r.empty), VAL_W'(out_tdata[32]));
        check_field("is_full_flag", VAL_W'(exp_r.full), VAL_W'(out_tdata[33]));
        check_field("status", VAL_W'(exp_r.status), VAL_W'(out_tdata[35:34]));
      end
    end
  end

  // Offer one item, hold it until the transfer, then record the expected result
  task automatic send_op(input logic [CMD_W-1:0] cmd, input logic [SID_W-1:0] sid,
                         input logic [VAL_W-1:0] val);
    while (gap_en && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= IN_TDATA_W'({val, sid, cmd});
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_stack_op(cmd, sid, val));
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the selected capacity registers back to back; each write empties its stack
  task automatic write_caps(input logic [STACKS-1:0] sel,
                            input logic [STACKS-1:0][CAPREG_W-1:0] caps);
    for (int i = 0; i < STACKS; i++) begin
      if (sel[i]) begin
        cfg_index <= CFG_IDX_W'(i);
        cfg_data <= caps[i];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cap_reg[i] = caps[i];
        fill_cnt[i] = 0;
      end
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return $urandom;
  endfunction

  function automatic logic [CAPREG_W-1:0] pick_capacity();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 60) return CAPREG_W'($urandom_range(6, 1));
    if (r < 75) return CAPREG_W'($urandom_range(63, 7));
    if (r < 85) return CAPREG_W'(DEPTH);
    return CAPREG_W'($urandom_range(127, 65));
  endfunction

  // Send one random operation, mostly aimed at live stacks
  task automatic send_random_op();
    int r;
    int live_ids[$];
    logic [CMD_W-1:0] cmd;
    logic [SID_W-1:0] sid;
    r = $urandom_range(99);
    if (r < 45) cmd = CMD_PUSH;
    else if (r < 75) cmd = CMD_POP;
    else cmd = $urandom_range(1) ? CMD_TOP : CMD_TOP_ALT;
    for (int i = 0; i < STACKS; i++) if (cap_reg[i] != 0) live_ids.push_back(i);
    if (live_ids.size() != 0 && $urandom_range(99) < 85)
      sid = SID_W'(live_ids[$urandom_range(live_ids.size() - 1)]);
    else
      sid = SID_W'($urandom_range(STACKS - 1));
    send_op(cmd, sid, pick_value());
  endtask

  // Every command on stacks that were never created
  task automatic test_unconfigured();
    for (int c = 0; c < 4; c++) begin
      send_op(CMD_W'(c), '0, '1);
      send_op(CMD_W'(c), SID_W'(STACKS - 1), '0);
    end
    drain_results();
  endtask

  // Capacity one and two, overflow, underflow, both read-top codes, missing stack
  task automatic test_edges();
    logic [STACKS-1:0][CAPREG_W-1:0] caps;
    caps = '0;
    caps[0] = 7'd1;
    caps[1] = 7'd64;
    caps[2] = 7'd127;
    caps[3] = 7'd65;
    caps[7] = 7'd2;
    write_caps(8'hFF, caps);
    send_op(CMD_PUSH, 3'd0, 32'hFFFF_FFFF);
    send_op(CMD_PUSH, 3'd0, 32'h0000_0000);
    send_op(CMD_TOP, 3'd0, 32'h0);
    send_op(CMD_TOP_ALT, 3'd0, 32'h0);
    send_op(CMD_POP, 3'd0, 32'h0);
    send_op(CMD_POP, 3'd0, 32'h0);
    send_op(CMD_TOP, 3'd0, 32'h0);
    send_op(CMD_TOP_ALT, 3'd0, 32'h0);
    send_op(CMD_PUSH, 3'd7, 32'h0000_0000);
    send_op(CMD_PUSH, 3'd7, 32'hFFFF_FFFF);
    send_op(CMD_PUSH, 3'd7, 32'h1234_5678);
    send_op(CMD_POP, 3'd7, 32'h0);
    send_op(CMD_POP, 3'd7, 32'h0);
    send_op(CMD_PUSH, 3'd1, 32'hA5A5_A5A5);
    send_op(CMD_PUSH, 3'd1, 32'h5A5A_5A5A);
    send_op(CMD_TOP_ALT, 3'd1, 32'h0);
    send_op(CMD_POP, 3'd1, 32'h0);
    send_op(CMD_POP, 3'd1, 32'h0);
    send_op(CMD_PUSH, 3'd5, 32'hDEAD_BEEF);
    send_op(CMD_POP, 3'd5, 32'h0);
    send_op(CMD_TOP, 3'd5, 32'h0);
    send_op(CMD_TOP_ALT, 3'd5, 32'h0);
    drain_results();
  endtask

  // Fill one stack past its saturated capacity, then empty it past the bottom
  task automatic test_full_depth(input logic [SID_W-1:0] sid);
    for (int i = 0; i <= DEPTH; i++) send_op(CMD_PUSH, sid, pick_value());
    send_op(CMD_TOP, sid, '0);
    for (int i = 0; i <= DEPTH; i++) send_op(CMD_POP, sid, pick_value());
    drain_results();
  endtask

  // Rewriting a capacity empties only that stack; zero removes it
  task automatic test_recreate();
    logic [STACKS-1:0][CAPREG_W-1:0] caps;
    caps = '0;
    caps[4] = 7'd3;
    caps[5] = 7'd3;
    write_caps(8'h30, caps);
    send_op(CMD_PUSH, 3'd4, 32'h0000_0004);
    send_op(CMD_PUSH, 3'd4, 32'h0000_0044);
    send_op(CMD_PUSH, 3'd5, 32'h0000_0005);
    drain_results();
    write_caps(8'h10, caps);
    send_op(CMD_TOP, 3'd4, '0);
    send_op(CMD_TOP, 3'd5, '0);
    drain_results();
    caps[5] = 7'd0;
    write_caps(8'h20, caps);
    send_op(CMD_PUSH, 3'd5, 32'h0000_0055);
    send_op(CMD_TOP, 3'd5, '0);
    drain_results();
    caps[5] = 7'd4;
    write_caps(8'h20, caps);
    send_op(CMD_TOP_ALT, 3'd5, '0);
    drain_results();
  endtask

  // Back-to-back transfers with no gaps or stalls
  task automatic test_burst(input int count);
    logic [STACKS-1:0][CAPREG_W-1:0] caps;
    for (int i = 0; i < STACKS; i++) caps[i] = pick_capacity();
    write_caps(8'hFF, caps);
    gap_en = 1'b0;
    stall_en = 1'b0;
    for (int i = 0; i < count; i++) send_random_op();
    drain_results();
    gap_en = 1'b1;
    stall_en = 1'b1;
  endtask

  // Random phases; odd phases rewrite every register, even ones a random subset
  task automatic test_random(input int phases, input int per_phase);
    logic [STACKS-1:0][CAPREG_W-1:0] caps;
    logic [STACKS-1:0] sel;
    for (int p = 0; p < phases; p++) begin
      for (int i = 0; i < STACKS; i++) caps[i] = pick_capacity();
      sel = (p % 2) ? 8'hFF : STACKS'($urandom_range(255, 1));
      write_caps(sel, caps);
      for (int i = 0; i < per_phase; i++) send_random_op();
      drain_results();
    end
  endtask

  initial begin
    for (int i = 0; i < STACKS; i++) begin
      cap_reg[i] = '0;
      fill_cnt[i] = 0;
    end
    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unconfigured();
    test_edges();
    test_full_depth(3'd2);
    test_full_depth(3'd3);
    test_recreate();
    test_burst(300);
    test_random(8, 150);

    // Let any stray result surface before judging
    repeat (TAIL_CYC) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
